// ----- rtl/core/sss_pkg.sv -----
// sss_pkg: shared types and constants for the sorted key set
// transfer structs, key layout, compare result and sequencer states
// no dependencies

package sss_pkg;

	localparam int unsigned POS_W = 11;

	localparam logic MODE_FIND = 1'b0;
	localparam logic MODE_ADD  = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [31:0] basin_key;
		logic        has_secondary;
		logic [31:0] secondary_index;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
		logic             added;
		logic             full_res;
		logic [POS_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] basin;
		logic        has_sec;
		logic [31:0] sec;
	} key_t;

	typedef enum logic [1:0] {
		ORD_LT,
		ORD_EQ,
		ORD_GT
	} ord_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT,
		ST_SHIFT_LAST,
		ST_INSERT,
		ST_DONE
	} state_t;

endpackage

// ----- rtl/core/sorted_set_search_insert.sv -----
// sorted_set_search_insert: ordered set of unique keys, find and add
// sequencer, key store memory and one shared key comparator
// depends on sss_pkg and sss_cmp
//
// Usage: a request (mode, basin_key, has_secondary, secondary_index) is
// transferred when req_valid is high and req_stall is low. Exactly one
// response follows on rsp, transferred when rsp_valid is high and rsp_stall
// is low. Only one request is worked on at a time; req_stall is low only
// while the sequencer is idle, and the next request may be taken while the
// previous response still waits in the output register.
// Sequence: a find runs a binary search, each probe a memory read in
// ST_SRCH_RD and then a compare in ST_SRCH_CMP. An add of a new key then
// moves the count - position later entries up by one, one entry per cycle
// through the key store's read and write port pair, followed by the last
// move (ST_SHIFT_LAST), the insert (ST_INSERT) and the response (ST_DONE).
// Reset empties the set (count to zero); the store contents are left as they
// are. If rsp_stall holds a response, a finished request waits in its last
// state until the output register is free.

module sorted_set_search_insert
	import sss_pkg::*;
#(
	parameter int unsigned CAPACITY = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

	key_t mem [CAPACITY];

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	key_t          key_q;
	logic          mode_q;
	logic [CW-1:0] lo_q, hi_q, mid_q, pos_q;
	logic [AW-1:0] idx_q, wa_q;
	logic          first_q, found_q, added_q, full_q;
	key_t          rdata_q;

	logic [AW-1:0] rd_addr, waddr;
	logic          we;
	key_t          wdata;
	ord_t          ord;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid, cnt_m1;
	logic          search_more, room, rsp_free;
	logic [XW-1:0] pos_x, cnt_x;

	sss_cmp u_cmp (
		.entry (rdata_q),
		.probe (key_q),
		.ord   (ord)
	);

	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid         = mid_sum[CW:1];
	assign cnt_m1      = count_q - CW'(1);
	assign search_more = lo_q < hi_q;
	assign room        = count_q < CW'(CAPACITY);
	assign rsp_free    = !rsp_valid_q || !rsp_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_SRCH_RD: begin
				if (search_more) begin
					state_d = ST_SRCH_CMP;
				end else if (mode_q == MODE_ADD && room) begin
					state_d = (lo_q == count_q) ? ST_INSERT : ST_SHIFT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SRCH_CMP: begin
				state_d = (ord == ORD_EQ) ? ST_DONE : ST_SRCH_RD;
			end
			ST_SHIFT: begin
				if (idx_q == pos_q[AW-1:0]) begin
					state_d = ST_SHIFT_LAST;
				end
			end
			ST_SHIFT_LAST: state_d = ST_INSERT;
			ST_INSERT:     state_d = ST_DONE;
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = 1'b1;
		rd_addr   = mid[AW-1:0];
		we        = 1'b0;
		waddr     = wa_q;
		wdata     = rdata_q;
		case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_SHIFT: begin
				rd_addr = idx_q;
				we      = !first_q;
			end
			ST_SHIFT_LAST: we = 1'b1;
			ST_INSERT: begin
				we    = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = key_q;
			end
			default: ;
		endcase
	end

	// key store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INSERT) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign pos_x = XW'(pos_q);
	assign cnt_x = XW'(count_q);

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mode_q        <= req.mode;
				key_q.basin   <= req.basin_key;
				key_q.has_sec <= req.has_secondary;
				key_q.sec     <= req.has_secondary ? req.secondary_index : 32'd0;
				lo_q          <= '0;
				hi_q          <= count_q;
				found_q       <= 1'b0;
				added_q       <= 1'b0;
				full_q        <= 1'b0;
			end
			ST_SRCH_RD: begin
				mid_q   <= mid;
				pos_q   <= lo_q;
				idx_q   <= cnt_m1[AW-1:0];
				first_q <= 1'b1;
				if (!search_more && mode_q == MODE_ADD && !room) begin
					full_q <= 1'b1;
				end
			end
			ST_SRCH_CMP: begin
				case (ord)
					ORD_EQ: begin
						found_q <= 1'b1;
						pos_q   <= mid_q;
					end
					ORD_GT:  hi_q <= mid_q;
					default: lo_q <= mid_q + CW'(1);
				endcase
			end
			ST_SHIFT: begin
				first_q <= 1'b0;
				wa_q    <= idx_q + AW'(1);
				idx_q   <= idx_q - AW'(1);
			end
			ST_INSERT: added_q <= 1'b1;
			ST_DONE: begin
				if (rsp_free) begin
					rsp_q.found       <= found_q;
					rsp_q.position    <= pos_x[POS_W-1:0];
					rsp_q.added       <= added_q;
					rsp_q.full_res    <= full_q;
					rsp_q.entry_count <= cnt_x[POS_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- rtl/core/sss_cmp.sv -----
// sss_cmp: orders a stored key against the probe key
// basin first, absent secondary before present, then secondary value
// depends on sss_pkg

module sss_cmp
	import sss_pkg::*;
(
	input  key_t entry,
	input  key_t probe,
	output ord_t ord
);

	always_comb begin
		if (entry.basin != probe.basin) begin
			ord = (entry.basin > probe.basin) ? ORD_GT : ORD_LT;
		end else if (!entry.has_sec && !probe.has_sec) begin
			ord = ORD_EQ;
		end else if (!entry.has_sec) begin
			ord = ORD_LT;
		end else if (!probe.has_sec) begin
			ord = ORD_GT;
		end else if (entry.sec > probe.sec) begin
			ord = ORD_GT;
		end else if (entry.sec < probe.sec) begin
			ord = ORD_LT;
		end else begin
			ord = ORD_EQ;
		end
	end

endmodule
